@@ design/sspq_pkg.sv @@
// sspq_pkg: operation and status codes and the entry type for the stable
// sorted priority queue. No dependencies.
package sspq_pkg;

    localparam int PRIO_W  = 16;
    localparam int VALUE_W = 32;
    localparam int FILL_W  = 5;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_PUSHED  = 3'd0;
    localparam logic [2:0] ST_POPPED  = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

@@ design/sspq_if.sv @@
// request and result channel interfaces of the stable sorted priority queue
// depends on sspq_pkg
interface spq_req_if;
    import sspq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic signed [PRIO_W-1:0] in_priority;
    logic signed [VALUE_W-1:0] in_value;

    modport source (output valid, output opcode, output in_priority, output in_value,
                    input ready);
    modport sink   (input valid, input opcode, input in_priority, input in_value,
                    output ready);
endinterface

interface spq_rsp_if;
    import sspq_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic signed [PRIO_W-1:0]  out_priority;
    logic signed [VALUE_W-1:0] out_value;
    logic [FILL_W-1:0]         fill_count;

    modport source (output valid, output status, output out_priority, output out_value,
                    output fill_count, input ready);
    modport sink   (input valid, input status, input out_priority, input out_value,
                    input fill_count, output ready);
endinterface

@@ design/sspq_cell.sv @@
// sspq_cell: one slot of the sorted chain, holds an entry and shifts with its
// neighbours on push and pop. Depends on sspq_pkg.
module sspq_cell (
    input  logic                clk,
    input  sspq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                prev_keep,
    input  sspq_pkg::entry_t    prev_entry,
    input  sspq_pkg::entry_t    next_entry,
    output logic                keep,
    output sspq_pkg::entry_t    entry
);
    import sspq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // entry stays in place when it ranks at or above the new one
    assign keep = occupied && ($signed(entry_reg.prio) >= $signed(ctrl.new_entry.prio));

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.push)
        begin
            if (keep)
                entry_next = entry_reg;
            else if (prev_keep)
                entry_next = ctrl.new_entry;
            else
                entry_next = prev_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = next_entry;
        end
        else
        begin
            // idle cycle, entry holds
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ design/stable_sorted_priority_queue.sv @@
// stable_sorted_priority_queue: top level, a chain of sspq_cell slots with the
// count, request decode and result register. Depends on sspq_pkg, sspq_if, sspq_cell.
//
// usage
//   req channel: one request per handshake, opcode push / pop / clear
//     (opcode 3 acts as clear) with the priority and value of a push
//   rsp channel: exactly one result per request, in request order, with
//     status, popped priority and value (zero unless popped) and fill count
//   entries sit sorted by descending priority, head in cell 0; a push goes
//     behind every entry of equal or higher priority, so ties leave in
//     arrival order
//   each cell compares its own priority with the pushed one in parallel and
//     the whole chain shifts by one slot at once
//   the result is registered, visible in the cycle after acceptance
//   throughput: one request per cycle; req.ready stays high while the result
//     register is empty or being taken in the same cycle
//   stall: a held result blocks only the next request, the result holds
//   reset: clears the count and the result valid; cell contents are not
//     reset and only occupied cells are ever read
//   a push into a full queue is dropped and reported as full
module stable_sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import sspq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                  out_valid_reg;
    logic [2:0]            status_reg;
    logic [2:0]            status_next;
    logic [PRIO_W-1:0]     out_prio_reg;
    logic [PRIO_W-1:0]     out_prio_next;
    logic [VALUE_W-1:0]    out_value_reg;
    logic [VALUE_W-1:0]    out_value_next;

    logic        accept;
    logic        is_push;
    logic        is_pop;
    logic        is_full;
    logic        is_empty;
    cell_ctrl_t  ctrl;

    entry_t     cell_entry [CAPACITY];
    logic       cell_keep  [CAPACITY];

    // a new request goes in when the result slot is free or being drained
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign is_push  = (req.opcode == OP_PUSH);
    assign is_pop   = (req.opcode == OP_POP);
    assign is_full  = (count_reg >= CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // cells only move on an accepted push with room or a pop with an entry
    assign ctrl.push            = accept && is_push && !is_full;
    assign ctrl.pop             = accept && is_pop && !is_empty;
    assign ctrl.new_entry.prio  = req.in_priority;
    assign ctrl.new_entry.value = req.in_value;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   occupied;
        logic   prev_keep;
        entry_t prev_entry;
        entry_t next_entry;

        assign occupied = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            // the head takes the new entry whenever it does not keep its own
            assign prev_keep  = 1'b1;
            assign prev_entry = ctrl.new_entry;
        end
        else
        begin : g_body
            assign prev_keep  = cell_keep[i-1];
            assign prev_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign next_entry = cell_entry[i+1];
        end

        sspq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occupied),
            .prev_keep  (prev_keep),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .keep       (cell_keep[i]),
            .entry      (cell_entry[i])
        );
    end

    // request decode, clear on opcode bit 1
    always_comb
    begin
        count_next     = count_reg;
        status_next    = ST_CLEARED;
        out_prio_next  = '0;
        out_value_next = '0;
        priority if (is_push)
        begin
            if (is_full)
                status_next = ST_FULL;
            else
            begin
                status_next = ST_PUSHED;
                count_next  = count_reg + CNT_W'(1);
            end
        end
        else if (is_pop)
        begin
            if (is_empty)
                status_next = ST_EMPTY;
            else
            begin
                status_next    = ST_POPPED;
                out_prio_next  = cell_entry[0].prio;
                out_value_next = cell_entry[0].value;
                count_next     = count_reg - CNT_W'(1);
            end
        end
        else
        begin
            status_next = ST_CLEARED;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            out_prio_reg  <= out_prio_next;
            out_value_reg <= out_value_next;
        end
    end

    logic [CNT_W-1:0] fill_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
            fill_reg <= count_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_priority = out_prio_reg;
    assign rsp.out_value    = out_value_reg;
    assign rsp.fill_count   = FILL_W'(fill_reg);

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_pop && !is_empty) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not remove one entry");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_push && is_full) |=> ($stable(count_reg) && status_reg == ST_FULL))
        else $error("push into full queue not dropped");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.opcode[1]) |=> (count_reg == '0 && status_reg == ST_CLEARED))
        else $error("clear left entries");

    a_fill_match: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (fill_reg == count_reg))
        else $error("reported fill differs from count");

endmodule

@@ test/stable_sorted_priority_queue_tb.sv @@
// stable_sorted_priority_queue_tb: self-checking testbench for the stable sorted priority queue
// depends on sspq_pkg, sspq_if (spq_req_if, spq_rsp_if) and stable_sorted_priority_queue
module stable_sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sspq_pkg::*;

    localparam int CAPACITY = 16;
    // opcode 3 is decoded on bit 1 and behaves as a clear
    localparam logic [1:0] OP_CLEAR_ALIAS = 2'd3;
    localparam int TIMEOUT_NS = 4_000_000;

    // one expected result per request
    typedef struct packed {
        logic [2:0]                status;
        logic signed [PRIO_W-1:0]  prio;
        logic signed [VALUE_W-1:0] value;
        logic [FILL_W-1:0]         fill;
    } queue_result_t;

    logic clk;
    logic rst_n;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    stable_sorted_priority_queue #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if.sink),
        .rsp  (rsp_if.source)
    );

    // shadow of the sorted store, head in slot 0
    logic signed [PRIO_W-1:0] shadow_prio [CAPACITY];
    logic [VALUE_W-1:0]       shadow_value [CAPACITY];
    int unsigned              shadow_count;

    queue_result_t pending_results[$];
    int unsigned   error_count;

    // idling controls, shared by the test tasks and the two channel sides
    bit req_idle_on;
    bit rsp_idle_on;
    int unsigned rsp_hold_request;
    int unsigned rsp_hold_left;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // safety net: a hung handshake ends the run
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    // predicted outcome of one request, updating the shadow store
    function automatic queue_result_t queue_outcome(input logic [1:0] op,
                                                    input logic signed [PRIO_W-1:0] prio,
                                                    input logic [VALUE_W-1:0] value);
        queue_result_t r;
        int unsigned   pos;
        int unsigned   i;
        r.status = ST_CLEARED;
        r.prio   = '0;
        r.value  = '0;
        if (op[1])
        begin
            // clear, and opcode 3 through the same decode
            shadow_count = 0;
            r.status     = ST_CLEARED;
        end
        else if (op == OP_POP)
        begin
            if (shadow_count == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.prio  = shadow_prio[0];
                r.value = shadow_value[0];
                for (i = 1; i < shadow_count; i++)
                begin
                    shadow_prio[i-1]  = shadow_prio[i];
                    shadow_value[i-1] = shadow_value[i];
                end
                shadow_count--;
                r.status = ST_POPPED;
            end
        end
        else
        begin
            if (shadow_count >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // behind every entry of equal or higher priority, so ties stay in order
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= prio)
                    pos++;
                for (i = shadow_count; i > pos; i--)
                begin
                    shadow_prio[i]  = shadow_prio[i-1];
                    shadow_value[i] = shadow_value[i-1];
                end
                shadow_prio[pos]  = prio;
                shadow_value[pos] = value;
                shadow_count++;
                r.status = ST_PUSHED;
            end
        end
        r.fill = FILL_W'(shadow_count);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at %0t: %s expected %0h got %0h", $realtime, field, want, got);
        error_count++;
    endtask

    // one request: random idle gap, then hold valid until the handshake
    task automatic send_request(input logic [1:0] op, input logic signed [PRIO_W-1:0] prio,
                                input logic [VALUE_W-1:0] value);
        while (req_idle_on && $urandom_range(0, 99) < 31)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.opcode      <= op;
        req_if.in_priority <= prio;
        req_if.in_value    <= value;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        // accepted at this edge
        pending_results.push_back(queue_outcome(op, prio, value));
    endtask

    // drop valid so an accepted request is not offered twice
    task automatic end_requests();
        req_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // priority mix: full range, a narrow band for ties, or an extreme
    function automatic logic signed [PRIO_W-1:0] pick_priority();
        logic signed [PRIO_W-1:0] p;
        case ($urandom_range(0, 3))
            0: p = PRIO_W'($urandom_range(0, 4)) - PRIO_W'(2);
            1: p = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: p = PRIO_W'($urandom);
        endcase
        return p;
    endfunction

    // receiver side: random stalls, or a counted hold-off when a test asks
    always @(posedge clk)
    begin
        if (rsp_hold_request != 0)
        begin
            rsp_hold_left    = rsp_hold_request;
            rsp_hold_request = 0;
        end
        if (rsp_hold_left != 0)
        begin
            rsp_hold_left--;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= !(rsp_idle_on && $urandom_range(0, 99) < 31);
        end
    end

    // result checker, compares against the oldest prediction
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result status", 32'h0, 32'(rsp_if.status));
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(rsp_if.status));
                if (rsp_if.out_priority !== want.prio)
                    report_mismatch("out_priority", 32'(want.prio), 32'(rsp_if.out_priority));
                if (rsp_if.out_value !== want.value)
                    report_mismatch("out_value", want.value, rsp_if.out_value);
                if (rsp_if.fill_count !== want.fill)
                    report_mismatch("fill_count", 32'(want.fill), 32'(rsp_if.fill_count));
            end
        end
    end

    // extremes, ties, every opcode, pop on empty
    task automatic test_directed_ops();
        send_request(OP_POP, 16'sh0000, 32'h0);
        send_request(OP_PUSH, 16'sh7fff, 32'h7fffffff);
        send_request(OP_PUSH, 16'sh8000, 32'h80000000);
        send_request(OP_PUSH, 16'sh0000, 32'h00000000);
        send_request(OP_PUSH, 16'sh0000, 32'hffffffff);
        send_request(OP_PUSH, 16'shffff, 32'h00000001);
        repeat (5)
            send_request(OP_POP, 16'sh0000, 32'h0);
        send_request(OP_POP, 16'shffff, 32'hffffffff);
        send_request(OP_PUSH, 16'sh0005, 32'h0000aaaa);
        send_request(OP_PUSH, 16'sh0005, 32'h00005555);
        send_request(OP_CLEAR_ALIAS, 16'sh1234, 32'h12345678);
        send_request(OP_POP, 16'sh0000, 32'h0);
        send_request(OP_PUSH, 16'sh0001, 32'h00000002);
        send_request(OP_CLEAR, 16'sh0000, 32'h0);
        end_requests();
    endtask

    // fill with tied priorities, push into a full queue, then drain past empty
    task automatic test_fill_and_overflow();
        repeat (CAPACITY)
            send_request(OP_PUSH, PRIO_W'($urandom_range(0, 3)), $urandom);
        repeat (2)
            send_request(OP_PUSH, pick_priority(), $urandom);
        repeat (CAPACITY + 1)
            send_request(OP_POP, PRIO_W'($urandom), $urandom);
        end_requests();
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_stall();
        req_idle_on      = 1'b0;
        rsp_hold_request = 120;
        repeat (24)
            send_request($urandom_range(0, 2) != 0 ? OP_PUSH : OP_POP, pick_priority(), $urandom);
        end_requests();
        req_idle_on = 1'b1;
    endtask

    // mixed traffic in chunks, each with its own push bias
    task automatic test_random_traffic();
        int unsigned push_bias;
        int unsigned roll;
        logic [1:0]  op;
        for (int chunk = 0; chunk < 20; chunk++)
        begin
            // chunks 8 to 11 run with no idling on either side
            req_idle_on = !(chunk >= 8 && chunk < 12);
            rsp_idle_on = req_idle_on;
            case ($urandom_range(0, 2))
                0: push_bias = 300;
                1: push_bias = 500;
                default: push_bias = 700;
            endcase
            repeat (50)
            begin
                roll = $urandom_range(0, 999);
                if (roll < push_bias)
                    op = OP_PUSH;
                else if (roll < 985)
                    op = OP_POP;
                else if (roll < 995)
                    op = OP_CLEAR;
                else
                    op = OP_CLEAR_ALIAS;
                send_request(op, pick_priority(), $urandom);
            end
        end
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        end_requests();
    endtask

    initial
    begin
        req_if.valid       = 1'b0;
        req_if.opcode      = OP_PUSH;
        req_if.in_priority = '0;
        req_if.in_value    = '0;
        rsp_if.ready       = 1'b0;
        shadow_count       = 0;
        error_count        = 0;
        req_idle_on        = 1'b1;
        rsp_idle_on        = 1'b1;
        rsp_hold_request   = 0;
        rsp_hold_left      = 0;
        rst_n              = 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_fill_and_overflow();
        test_output_stall();
        test_random_traffic();

        // let every outstanding result come back, then let the clock idle before the verdict
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
